// ===== rtl/core/lpfr_pkg.sv =====
// shared constants, types and helpers for the lru page frame replacer
// no dependencies; compiled first
`default_nettype none

package lpfr_pkg;

	// default geometry of the frame table
	localparam int unsigned DEF_NUM_FRAMES    = 8;
	localparam int unsigned DEF_NUM_PAGES     = 16;
	localparam int unsigned DEF_NUM_PROCESSES = 2;

	// saturating age counter per frame
	localparam int unsigned        AGE_W   = 4;
	localparam logic [AGE_W-1:0]   AGE_MAX = {AGE_W{1'b1}};

	// bits needed for an identifier with n distinct values, at least one
	function automatic int unsigned id_width(input int unsigned n);
		int unsigned w;
		w = (n > 1) ? $clog2(n) : 1;
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpfr_if.sv =====
// valid/ready channel interfaces for lookup and result beats
// depends on lpfr_pkg for default widths
`default_nettype none

interface lpfr_lookup_if
	import lpfr_pkg::*;
#(
	parameter int unsigned PROC_W = id_width(DEF_NUM_PROCESSES),
	parameter int unsigned PAGE_W = id_width(DEF_NUM_PAGES)
);
	logic              valid;
	logic              ready;
	logic [PROC_W-1:0] process_id;
	logic [PAGE_W-1:0] page_number;

	modport source (output valid, process_id, page_number, input ready);
	modport sink   (input valid, process_id, page_number, output ready);
endinterface

interface lpfr_result_if
	import lpfr_pkg::*;
#(
	parameter int unsigned PROC_W = id_width(DEF_NUM_PROCESSES),
	parameter int unsigned PAGE_W = id_width(DEF_NUM_PAGES),
	parameter int unsigned IDX_W  = $clog2(DEF_NUM_FRAMES)
);
	logic              valid;
	logic              ready;
	logic              hit;
	logic [IDX_W-1:0]  frame_index;
	logic              victim_valid;
	logic [PROC_W-1:0] victim_process;
	logic [PAGE_W-1:0] victim_page;

	modport source (output valid, hit, frame_index, victim_valid, victim_process,
		victim_page, input ready);
	modport sink   (input valid, hit, frame_index, victim_valid, victim_process,
		victim_page, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpfr_cell.sv =====
// one frame of the replacer: holds valid, owner, page and age, and folds
// its entry into the scan token passed along the chain; uses lpfr_pkg
`default_nettype none

module lpfr_cell
	import lpfr_pkg::*;
#(
	parameter int unsigned NUM_FRAMES = DEF_NUM_FRAMES,
	parameter int unsigned IDX        = 0,
	parameter int unsigned PROC_W     = id_width(DEF_NUM_PROCESSES),
	parameter int unsigned PAGE_W     = id_width(DEF_NUM_PAGES),
	parameter type         tok_t      = logic,
	parameter type         upd_t      = logic
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [PROC_W-1:0] query_proc,
	input  wire logic [PAGE_W-1:0] query_page,
	input  wire tok_t              tok_in,
	output tok_t                   tok_out,
	input  wire upd_t              upd
);

	localparam int unsigned IDX_W = $clog2(NUM_FRAMES);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic              valid_q;
	logic [PROC_W-1:0] owner_q;
	logic [PAGE_W-1:0] page_q;
	logic [AGE_W-1:0]  age_q;
	tok_t              tok_q;
	tok_t              tok_nxt;
	logic              match;
	logic              take_best;

	assign match     = valid_q && (owner_q == query_proc) && (page_q == query_page);
	assign take_best = (IDX == 0) || (age_q > tok_in.best_age);

	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.found && match) begin
			tok_nxt.found   = 1'b1;
			tok_nxt.hit_idx = MY_IDX;
		end
		if (!tok_in.free_found && !valid_q) begin
			tok_nxt.free_found = 1'b1;
			tok_nxt.free_idx   = MY_IDX;
		end
		if (take_best) begin
			tok_nxt.best_age   = age_q;
			tok_nxt.best_idx   = MY_IDX;
			tok_nxt.best_owner = owner_q;
			tok_nxt.best_page  = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

	// frame state update on the broadcast commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			owner_q <= '0;
			page_q  <= '0;
			age_q   <= '0;
		end else if (upd.en) begin
			if (upd.idx == MY_IDX) begin
				age_q <= '0;
				if (upd.load) begin
					valid_q <= 1'b1;
					owner_q <= query_proc;
					page_q  <= query_page;
				end
			end else if (valid_q && (age_q != AGE_MAX)) begin
				age_q <= age_q + AGE_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_frame_replacer.sv =====
// top level of the lru page frame replacer: controller, chain of frame cells
// and result register; depends on lpfr_pkg, lpfr_if and lpfr_cell
//
// usage
//   lookup channel: one beat per page reference (process_id, page_number)
//   result channel: one beat per reference (hit, frame_index, victim_valid,
//     victim_process, victim_page); a victim is reported only when an
//     occupied frame is evicted, its fields are zero otherwise
// timing
//   a scan token walks the frame chain one cell per cycle, from the start
//   register through every cell register to the final token register; the
//   commit then waits until the result register is free and loads the result
//   beat; the next lookup beat is taken only once the commit is done
//   one reference is in the chain at a time; lookup ready is high when idle
// reset
//   arst_n clears all frames to free, the scan chain and the valid flag of the result register
// stall
//   a pending result beat does not block the next lookup; the chain scans
//   and waits to commit until the result register has been emptied
`default_nettype none

module lru_page_frame_replacer
	import lpfr_pkg::*;
#(
	parameter int unsigned NUM_FRAMES    = DEF_NUM_FRAMES,
	parameter int unsigned NUM_PAGES     = DEF_NUM_PAGES,
	parameter int unsigned NUM_PROCESSES = DEF_NUM_PROCESSES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lpfr_lookup_if.sink   lookup,
	lpfr_result_if.source result
);

	localparam int unsigned IDX_W  = $clog2(NUM_FRAMES);
	localparam int unsigned PROC_W = id_width(NUM_PROCESSES);
	localparam int unsigned PAGE_W = id_width(NUM_PAGES);

	// controller states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	// scan token: first hit, first free frame, oldest frame so far
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [IDX_W-1:0]  hit_idx;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
		logic [AGE_W-1:0]  best_age;
		logic [IDX_W-1:0]  best_idx;
		logic [PROC_W-1:0] best_owner;
		logic [PAGE_W-1:0] best_page;
	} tok_t;

	// commit broadcast to all cells
	typedef struct packed {
		logic             en;
		logic             load;
		logic [IDX_W-1:0] idx;
	} upd_t;

	logic [1:0]        state_q;
	logic              start_q;
	logic [PROC_W-1:0] proc_q;
	logic [PAGE_W-1:0] page_q;
	tok_t              final_q;
	tok_t              chain [NUM_FRAMES+1];
	upd_t              upd;

	logic              accept;
	logic              out_free;
	logic              victim;

	logic              rvalid_q;
	logic              hit_q;
	logic [IDX_W-1:0]  idx_q;
	logic              vvalid_q;
	logic [PROC_W-1:0] vproc_q;
	logic [PAGE_W-1:0] vpage_q;

	assign lookup.ready = (state_q == ST_IDLE);
	assign accept       = lookup.valid && lookup.ready;
	assign out_free     = !rvalid_q || result.ready;

	// token enters the chain in the cycle after the lookup beat
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = start_q;
	end

	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		lpfr_cell #(
			.NUM_FRAMES (NUM_FRAMES),
			.IDX        (i),
			.PROC_W     (PROC_W),
			.PAGE_W     (PAGE_W),
			.tok_t      (tok_t),
			.upd_t      (upd_t)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.query_proc (proc_q),
			.query_page (page_q),
			.tok_in     (chain[i]),
			.tok_out    (chain[i+1]),
			.upd        (upd)
		);
	end

	// pick the frame: hit, else lowest free, else oldest
	always_comb begin
		upd.en   = (state_q == ST_UPD) && out_free;
		upd.load = 1'b1;
		upd.idx  = final_q.best_idx;
		victim   = 1'b0;
		if (final_q.found) begin
			upd.load = 1'b0;
			upd.idx  = final_q.hit_idx;
		end else if (final_q.free_found) begin
			upd.idx  = final_q.free_idx;
		end else begin
			victim   = 1'b1;
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[NUM_FRAMES].valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query and tail token capture
	always_ff @(posedge clk) begin
		if (accept) begin
			proc_q <= lookup.process_id;
			page_q <= lookup.page_number;
		end
		if ((state_q == ST_SCAN) && chain[NUM_FRAMES].valid) begin
			final_q <= chain[NUM_FRAMES];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (upd.en) begin
			rvalid_q <= 1'b1;
		end else if (result.ready) begin
			rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			hit_q    <= final_q.found;
			idx_q    <= upd.idx;
			vvalid_q <= victim;
			vproc_q  <= victim ? final_q.best_owner : '0;
			vpage_q  <= victim ? final_q.best_page : '0;
		end
	end

	assign result.valid          = rvalid_q;
	assign result.hit            = hit_q;
	assign result.frame_index    = idx_q;
	assign result.victim_valid   = vvalid_q;
	assign result.victim_process = vproc_q;
	assign result.victim_page    = vpage_q;

	// a commit never overwrites a result beat still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en |-> (!rvalid_q || result.ready))
		else $error("result register overwritten");

	// the scan token only reaches the tail while scanning
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[NUM_FRAMES].valid |-> (state_q == ST_SCAN))
		else $error("scan token at tail outside scan");

	// a lookup beat launches exactly one token into the chain
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (start_q && (state_q == ST_SCAN)))
		else $error("token not launched after lookup beat");

	// a hit never reports a victim
	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(rvalid_q && hit_q) |-> !vvalid_q)
		else $error("hit reported with victim");

endmodule

`default_nettype wire
